/* hdl/swm_pkg.sv */
`timescale 1ns / 1ps

package swm_pkg;

   // Default build sizes
   localparam int unsigned WINDOW_MAX_DEF  = 32;
   localparam int unsigned SAMPLE_BITS_DEF = 16;

   // Width of the window size write port and the window size after reset
   localparam int unsigned WSIZE_BITS  = 6;
   localparam int unsigned WSIZE_RESET = 32;

   // Control from the handshake side to the sorted cell row
   typedef struct packed {
      logic push;    // a sample word is taken this cycle
      logic clear;   // window size written: empty the window
   } swm_ctl_type;

endpackage

/* hdl/swm_sorter.sv */
`timescale 1ns / 1ps

module swm_sorter #(
   parameter int unsigned WINDOW_MAX  = 32,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swm_pkg::swm_ctl_type                   ctl,
   input  logic [$clog2(WINDOW_MAX + 1) - 1:0]    win,
   input  logic signed [SAMPLE_BITS - 1:0]        key,
   output logic                                   done,
   output logic signed [SAMPLE_BITS - 1:0]        median
);
   import swm_pkg::*;

   localparam int unsigned N  = WINDOW_MAX;
   localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
   localparam int unsigned CW = $clog2(N + 1);

   // Sorted cells: value and age of each held sample, lowest value in cell 0
   logic signed [SAMPLE_BITS - 1:0] val_ff [N];
   logic signed [SAMPLE_BITS - 1:0] val_in [N];
   logic [AW - 1:0]                 age_ff [N];
   logic [AW - 1:0]                 age_in [N];
   logic [CW - 1:0]                 cnt_ff;
   logic [CW - 1:0]                 cnt_in;

   logic                            full;
   logic [CW - 1:0]                 cnt_left;
   logic [AW - 1:0]                 age_last;
   logic [N - 1:0]                  rm;
   logic [N - 1:0]                  gone;
   logic [N - 1:0]                  le;
   logic [N - 1:0]                  cvalid;
   logic signed [SAMPLE_BITS - 1:0] cv [N];
   logic [AW - 1:0]                 ca [N];
   logic [AW - 1:0]                 mid;

   // Window state after the oldest sample leaves
   assign full     = (cnt_ff == win);
   assign cnt_left = full ? (cnt_ff - CW'(1)) : cnt_ff;
   assign age_last = AW'(win - CW'(1));
   assign cnt_in   = cnt_left + CW'(1);
   assign done     = (cnt_in == win);
   assign mid      = AW'((win - CW'(1)) >> 1);

   genvar j;
   generate
      for (j = 0; j < N; j++) begin : g_cell
         // Mark the cell that holds the oldest sample
         assign rm[j]     = full && (CW'(j) < cnt_ff) && (age_ff[j] == age_last);
         assign gone[j]   = |rm[j:0];
         assign cvalid[j] = (CW'(j) < cnt_left);

         // Close the gap left by the removed sample
         if (j + 1 < N) begin : g_up
            assign cv[j] = gone[j] ? val_ff[j + 1] : val_ff[j];
            assign ca[j] = gone[j] ? age_ff[j + 1] : age_ff[j];
         end else begin : g_top
            assign cv[j] = val_ff[j];
            assign ca[j] = age_ff[j];
         end

         // Cells at or below the new sample keep their place
         assign le[j] = cvalid[j] && (cv[j] <= key);

         // Insert the new sample above the last smaller or equal one
         if (j == 0) begin : g_first
            always_comb begin
               if (le[j]) begin
                  val_in[j] = cv[j];
                  age_in[j] = ca[j] + AW'(1);
               end else begin
                  val_in[j] = key;
                  age_in[j] = '0;
               end
            end
         end else begin : g_rest
            always_comb begin
               if (le[j]) begin
                  val_in[j] = cv[j];
                  age_in[j] = ca[j] + AW'(1);
               end else if (le[j - 1]) begin
                  val_in[j] = key;
                  age_in[j] = '0;
               end else begin
                  val_in[j] = cv[j - 1];
                  age_in[j] = ca[j - 1] + AW'(1);
               end
            end
         end

         // Advance the cell on each taken word
         always_ff @(posedge clock) begin
            if (ctl.push) begin
               val_ff[j] <= val_in[j];
               age_ff[j] <= age_in[j];
            end
         end
      end
   endgenerate

   // Lower median of the updated window
   assign median = val_in[mid];

   // Hold the number of samples in the window
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         cnt_ff <= '0;
      end else if (ctl.push) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/sliding_window_median.sv */
`timescale 1ns / 1ps

// Running median filter over the last window_size signed samples.
// Input channel req_*: one sample word per handshake (req_valid/req_ready).
// Result channel rsp_*: one lower median word per handshake; a result is
// produced for the sample that fills the window and for every later one.
// For an even window the lower median is given, the element at position
// (window_size+1)/2 counted from the smallest.
// csr_wr_en/csr_wr_data write window_size (1..WINDOW_MAX; 0 acts as 1,
// larger values saturate). Every write empties the window.
// Result: registered, shown on rsp_* in the cycle after its sample is taken.
// Throughput: one sample per cycle unless the output stalls. The sorted
// cell row updates all cells in one pass: each cell compares with the new
// sample and drops the oldest by its age, so only the output can stall.
// Reset: the window is empty, window_size is 32 (capped at WINDOW_MAX),
// and no result is pending.
// Stall: a result waits in the output register while rsp_ready is low;
// req_ready is low only while that register is full and not being taken.
module sliding_window_median #(
   parameter int unsigned WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
   parameter int unsigned SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS - 1:0]     req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS - 1:0]     rsp_median,
   input  logic                                csr_wr_en,
   input  logic [swm_pkg::WSIZE_BITS - 1:0]    csr_wr_data
);
   import swm_pkg::*;

   localparam int unsigned CW = $clog2(WINDOW_MAX + 1);

   logic [CW - 1:0]                 win_ff;
   logic [CW - 1:0]                 win_in;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_BITS - 1:0] rsp_median_ff;
   swm_ctl_type                     ctl;
   logic                            take;
   logic                            done;
   logic signed [SAMPLE_BITS - 1:0] median;

   // Effective window size from the written value
   always_comb begin
      if (csr_wr_data == '0) begin
         win_in = CW'(1);
      end else if (32'(csr_wr_data) > 32'(WINDOW_MAX)) begin
         win_in = CW'(WINDOW_MAX);
      end else begin
         win_in = CW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= (WSIZE_RESET > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(WSIZE_RESET);
      end else if (csr_wr_en) begin
         win_ff <= win_in;
      end
   end

   // Take a word whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   assign ctl.push  = take;
   assign ctl.clear = csr_wr_en;

   swm_sorter #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_sorter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .win    (win_ff),
      .key    (req_sample),
      .done   (done),
      .median (median)
   );

   // Load the result word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && done) begin
         rsp_median_ff <= median;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

/* tb/sv/sliding_window_median_tb.sv */
`timescale 1ns / 1ps

typedef logic signed [swm_pkg::SAMPLE_BITS_DEF - 1:0] sample_type;
typedef logic [swm_pkg::WSIZE_BITS - 1:0] wsize_type;

// Tracks the running window and the medians still owed by the block
class median_scoreboard;
   localparam int unsigned WMAX = swm_pkg::WINDOW_MAX_DEF;

   sample_type history [WMAX];
   sample_type ordered [WMAX];
   int unsigned held;
   int unsigned oldest;
   wsize_type wsize;
   sample_type expected_medians [$];
   int unsigned mismatches;
   int unsigned medians_checked;

   function new();
      wsize = wsize_type'(swm_pkg::WSIZE_RESET);
      held = 0;
      oldest = 0;
      mismatches = 0;
      medians_checked = 0;
   endfunction

   // Any write empties the window, an unchanged value too
   function void set_window(wsize_type value);
      wsize = value;
      held = 0;
      oldest = 0;
   endfunction

   function int unsigned pending();
      return expected_medians.size();
   endfunction

   // Place a sample into the ascending copy
   function void insert_ordered(sample_type s);
      int unsigned pos;
      if (held >= WMAX) return;
      pos = held;
      while (pos > 0 && ordered[pos - 1] > s) begin
         ordered[pos] = ordered[pos - 1];
         pos--;
      end
      ordered[pos] = s;
      held++;
   endfunction

   // Advance the window by one accepted sample word
   function void note_sample(sample_type s);
      int unsigned w;
      int unsigned i;
      int unsigned j;
      sample_type gone;
      w = wsize;
      if (w == 0) w = 1;
      if (w > WMAX) w = WMAX;
      if (oldest >= w) oldest = 0;
      if (held > w) held = 0;
      if (held < w) begin
         history[(oldest + held) % w] = s;
         insert_ordered(s);
      end else begin
         // drop the oldest by value, then take the new one in
         gone = history[oldest];
         i = 0;
         while (i < held && ordered[i] != gone) i++;
         if (i < held) begin
            for (j = i; j + 1 < held; j++) ordered[j] = ordered[j + 1];
            held--;
         end
         insert_ordered(s);
         history[oldest] = s;
         oldest = (oldest + 1) % w;
      end
      if (held == w)
         expected_medians.insert(expected_medians.size(), ordered[(w - 1) / 2]);
   endfunction

   // Compare a median word with the oldest one owed
   function void check_median(sample_type got);
      sample_type want;
      medians_checked++;
      if (expected_medians.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("median %0d arrived with none pending", got);
      end else begin
         want = expected_medians.pop_front();
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("median mismatch: expected %0d, got %0d", want, got);
         end
      end
   endfunction
endclass

module sliding_window_median_tb;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned PHASES = 12;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   sample_type req_sample = '0;
   logic rsp_ready = 1'b0;
   logic csr_wr_en = 1'b0;
   wsize_type csr_wr_data = '0;
   logic req_ready;
   logic rsp_valid;
   sample_type rsp_median;

   median_scoreboard sb = new();
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned window_writes = 0;
   int unsigned samples_taken = 0;

   // Directed words: partial fill at the reset window, then odd, single and even windows
   sample_type warm_up [6] = '{100, -100, 0, 32767, -32768, 7};
   sample_type corner_odd [14] = '{32767, -32768, 0, -1, 1, -32768, -32768,
                                   32767, 32767, 32767, 5, 5, 21845, -21846};
   sample_type corner_single [3] = '{-32768, 32767, -1};
   sample_type corner_even [4] = '{10, -10, 32767, -32768};

   // Random phases: window size written, idling pattern, word count
   wsize_type plan_window [PHASES] =
      '{63, 1, 33, 7, 2, 32, 0, 31, 9, 4, 16, 16};
   idle_mode_type plan_idle [PHASES] =
      '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_SENDER,
        IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER};
   int unsigned plan_count [PHASES] = '{60, 50, 60, 50, 40, 60, 40, 60, 45, 40, 25, 20};

   sliding_window_median uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_median  (rsp_median),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Observe both handshakes on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_sample(req_sample);
            samples_taken++;
         end
         if (rsp_valid && rsp_ready) sb.check_median(rsp_median);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic set_idle(idle_mode_type mode);
      gap_pct = (mode == IDLE_SENDER) ? 69 : (mode == IDLE_BOTH) ? 33 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 69 : (mode == IDLE_BOTH) ? 33 : 0;
   endtask

   // Offer one sample word and hold it until taken
   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drain the block, then write the window size
   task automatic write_window(wsize_type value);
      req_valid <= 1'b0;
      // step past the last accepting edge before looking at what is owed
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      sb.set_window(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_writes++;
   endtask

   initial begin
      sample_type prev;
      int unsigned flavour;
      int unsigned p;
      prev = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: partial fill must stay silent and be cleared by the write
      foreach (warm_up[k]) send_sample(warm_up[k]);
      write_window(6'd3);
      foreach (corner_odd[k]) send_sample(corner_odd[k]);
      // zero acts as a window of one
      write_window(6'd0);
      foreach (corner_single[k]) send_sample(corner_single[k]);
      // even window gives the lower median
      write_window(6'd2);
      foreach (corner_even[k]) send_sample(corner_even[k]);

      // Random phases, one window size each
      plan_window[8] = wsize_type'($urandom_range(1, 32));
      for (p = 0; p < PHASES; p++) begin
         write_window(plan_window[p]);
         set_idle(plan_idle[p]);
         repeat (plan_count[p]) begin
            flavour = $urandom_range(9);
            case (flavour)
               0, 1, 2, 3, 4: begin
                  prev = sample_type'($urandom);
               end
               5, 6, 7: begin
                  // tight cluster to force equal samples
                  prev = sample_type'(int'($urandom_range(8)) - 4);
               end
               8: begin
                  prev = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
                  prev[0] = prev[0] ^ 1'($urandom_range(1));
               end
               default: begin
                  // repeat the previous word
               end
            endcase
            send_sample(prev);
         end
      end

      // Drain and let any stray word show up
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES * 4) @(posedge clock);

      $display("Ran %0d sample words, %0d medians compared, %0d window size writes",
               samples_taken, sb.medians_checked, window_writes);
      $display("Windows of 1 to 32 incl. zero and saturated sizes, mismatches: %0d",
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
